FILE: rtl/core/lpmd_pkg.sv
`default_nettype none

package lpmd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 22;

  localparam int unsigned HdrMoreBit    = 7;
  localparam int unsigned HdrDeflateBit = 6;
  localparam int unsigned HdrShift      = 7;

  // one result request as it leaves the parser
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             first_of_message;
    logic             last_of_message;
    logic             empty_message;
    logic             huffman_coded;
    logic             deflated;
    logic [LenW-1:0]  message_length;
  } result_t;

  typedef struct packed {
    logic in_payload;
    logic bytes_left_zero;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/lpmd_parse.sv
`default_nettype none

module lpmd_parse import lpmd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic [ByteW-1:0] item_byte,
  input  wire logic             take,
  output result_t               res,
  output logic                  res_valid,
  output status_t               status
);

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_THIRD   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t          phase, phase_next;
  logic [LenW-1:0] size_accum, size_accum_next;
  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic            deflate_flag, deflate_flag_next;
  logic            first_pending, first_pending_next;
  logic            hdr_done;
  logic            last;

  always_comb begin
    phase_next         = phase;
    size_accum_next    = size_accum;
    bytes_left_next    = bytes_left;
    deflate_flag_next  = deflate_flag;
    first_pending_next = first_pending;
    hdr_done           = 1'b0;
    last               = (bytes_left <= LenW'(1));
    res_valid          = 1'b0;
    res.out_byte         = item_byte;
    res.first_of_message = first_pending;
    res.last_of_message  = last;
    res.empty_message    = 1'b0;

    unique case (phase)
      PH_FIRST: begin
        size_accum_next   = {{(LenW-7){1'b0}}, item_byte[6:0]};
        deflate_flag_next = 1'b0;
        if (item_byte[HdrMoreBit]) begin
          phase_next = PH_SECOND;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_SECOND: begin
        if (item_byte[HdrMoreBit]) begin
          size_accum_next = size_accum |
                            {{(LenW-14){1'b0}}, item_byte[6:0], {HdrShift{1'b0}}};
          deflate_flag_next = 1'b1;
          phase_next        = PH_THIRD;
        end else begin
          size_accum_next = size_accum |
                            {{(LenW-13){1'b0}}, item_byte[5:0], {HdrShift{1'b0}}};
          deflate_flag_next = item_byte[HdrDeflateBit];
          hdr_done          = 1'b1;
        end
      end
      PH_THIRD: begin
        size_accum_next   = size_accum | {item_byte, {(2*HdrShift){1'b0}}};
        deflate_flag_next = 1'b1;
        hdr_done          = 1'b1;
      end
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        first_pending_next = 1'b0;
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LenW'(1);
        end
        if (last) begin
          bytes_left_next    = '0;
          first_pending_next = 1'b1;
          phase_next         = PH_FIRST;
        end
      end
      default: begin
      end
    endcase

    if (hdr_done) begin
      first_pending_next = 1'b1;
      if (size_accum_next == '0) begin
        // zero size header: one empty-message request, then a new header
        res_valid            = 1'b1;
        res.out_byte         = '0;
        res.first_of_message = 1'b1;
        res.last_of_message  = 1'b1;
        res.empty_message    = 1'b1;
        phase_next           = PH_FIRST;
      end else begin
        bytes_left_next = size_accum_next;
        phase_next      = PH_PAYLOAD;
      end
    end

    res.deflated       = deflate_flag_next;
    res.huffman_coded  = ~deflate_flag_next;
    res.message_length = size_accum_next;
    res_valid          = res_valid & item_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      size_accum    <= '0;
      bytes_left    <= '0;
      deflate_flag  <= 1'b0;
      first_pending <= 1'b1;
    end else if (take) begin
      phase         <= phase_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      deflate_flag  <= deflate_flag_next;
      first_pending <= first_pending_next;
    end
  end

  assign status.in_payload      = (phase == PH_PAYLOAD);
  assign status.bytes_left_zero = (bytes_left == '0);

endmodule

`default_nettype wire

FILE: rtl/core/lpmd_out_reg.sv
`default_nettype none

module lpmd_out_reg import lpmd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    stall,
  output logic         valid,
  output result_t      data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/length_prefix_message_deframer.sv
// an accepted byte is held in the input register; its result request is then loaded into the output register
// throughput: one byte per cycle; a header byte that gives no result never waits
// on the output side, a result byte waits only while the output register is held
// reset (rst, synchronous): both pipeline registers empty, parser expects a
// first header byte
`default_nettype none

module length_prefix_message_deframer import lpmd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] in_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [ByteW-1:0]      out_byte,
  output logic                  first_of_message,
  output logic                  last_of_message,
  output logic                  empty_message,
  output logic                  huffman_coded,
  output logic                  deflated,
  output logic [LenW-1:0]       message_length
);

  logic             in_reg_valid;
  logic [ByteW-1:0] in_reg_byte;
  logic             advance;
  logic             out_free;
  logic             res_valid;
  result_t          res;
  result_t          out_data;
  status_t          status;

  assign out_free = ~out_valid | ~out_stall;
  assign advance  = in_reg_valid & (~res_valid | out_free);
  assign in_stall = in_reg_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg_byte <= in_byte;
    end
  end

  lpmd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_reg_valid),
    .item_byte  (in_reg_byte),
    .take       (advance),
    .res        (res),
    .res_valid  (res_valid),
    .status     (status)
  );

  lpmd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance & res_valid),
    .load_data (res),
    .stall     (out_stall),
    .valid     (out_valid),
    .data      (out_data)
  );

  assign out_byte         = out_data.out_byte;
  assign first_of_message = out_data.first_of_message;
  assign last_of_message  = out_data.last_of_message;
  assign empty_message    = out_data.empty_message;
  assign huffman_coded    = out_data.huffman_coded;
  assign deflated         = out_data.deflated;
  assign message_length   = out_data.message_length;

  // an empty-message request is a whole message of zero bytes
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_message |->
      first_of_message && last_of_message && message_length == '0 && out_byte == '0)
    else $error("empty message request malformed");

  a_coding_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> huffman_coded != deflated)
    else $error("coding flags not complementary");

  // payload phase always has at least one byte still owed
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    status.in_payload |-> !status.bytes_left_zero)
    else $error("payload phase with no bytes left");

  // a held input byte is not dropped
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !advance |=> in_reg_valid && $stable(in_reg_byte))
    else $error("stalled input byte lost");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lpmd_pkg::*;

  typedef enum logic [1:0] {HDR_FIRST, HDR_SECOND, HDR_THIRD, PAYLOAD} deframe_phase_e;
  typedef enum int {HDR_SMALL, HDR_MEDIUM, HDR_LARGE} hdr_kind_e;

  localparam int unsigned RandomBytes = 1250;
  localparam int unsigned MaxPrinted  = 20;
  localparam int unsigned DrainCycles = 10;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_byte   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             first_of_message;
  logic             last_of_message;
  logic             empty_message;
  logic             huffman_coded;
  logic             deflated;
  logic [LenW-1:0]  message_length;

  length_prefix_message_deframer u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .first_of_message (first_of_message),
    .last_of_message  (last_of_message),
    .empty_message    (empty_message),
    .huffman_coded    (huffman_coded),
    .deflated         (deflated),
    .message_length   (message_length)
  );

  logic [ByteW-1:0] framed_stream[$];
  result_t          deframed_expect[$];
  int               total_bytes;
  int               bytes_sent    = 0;
  int               results_seen  = 0;
  int               errors        = 0;
  int               msg_count     = 0;
  int               empty_count   = 0;
  int               payload_count = 0;

  // deframer state as the stream is accepted
  deframe_phase_e  dfr_phase   = HDR_FIRST;
  logic [LenW-1:0] dfr_size    = '0;
  logic [LenW-1:0] dfr_left    = '0;
  logic            dfr_deflate = 1'b0;
  logic            dfr_first   = 1'b1;

  function automatic result_t make_result(logic [ByteW-1:0] data, logic first, logic last,
                                          logic empty);
    result_t r;
    r.out_byte         = data;
    r.first_of_message = first;
    r.last_of_message  = last;
    r.empty_message    = empty;
    r.huffman_coded    = ~dfr_deflate;
    r.deflated         = dfr_deflate;
    r.message_length   = dfr_size;
    return r;
  endfunction

  task automatic deframe_step(input logic [ByteW-1:0] b);
    logic header_done;
    logic last;
    header_done = 1'b0;
    case (dfr_phase)
      HDR_FIRST: begin
        dfr_size    = LenW'(b[6:0]);
        dfr_deflate = 1'b0;
        if (b[HdrMoreBit]) dfr_phase = HDR_SECOND;
        else header_done = 1'b1;
      end
      HDR_SECOND: begin
        if (b[HdrMoreBit]) begin
          dfr_size    = dfr_size | (LenW'(b[6:0]) << HdrShift);
          dfr_deflate = 1'b1;
          dfr_phase   = HDR_THIRD;
        end else begin
          dfr_deflate = b[HdrDeflateBit];
          dfr_size    = dfr_size | (LenW'(b[5:0]) << HdrShift);
          header_done = 1'b1;
        end
      end
      HDR_THIRD: begin
        dfr_size    = dfr_size | (LenW'(b) << (2 * HdrShift));
        dfr_deflate = 1'b1;
        header_done = 1'b1;
      end
      default: begin
        last = (dfr_left <= 1);
        deframed_expect.push_back(make_result(b, dfr_first, last, 1'b0));
        payload_count++;
        dfr_first = 1'b0;
        if (dfr_left != 0) dfr_left = dfr_left - 1'b1;
        if (last) begin
          dfr_left  = '0;
          dfr_first = 1'b1;
          dfr_phase = HDR_FIRST;
        end
      end
    endcase
    if (header_done) begin
      msg_count++;
      dfr_first = 1'b1;
      if (dfr_size == 0) begin
        // zero size: one empty request, then straight back to a new header
        deframed_expect.push_back(make_result('0, 1'b1, 1'b1, 1'b1));
        empty_count++;
        dfr_phase = HDR_FIRST;
      end else begin
        dfr_left  = dfr_size;
        dfr_phase = PAYLOAD;
      end
    end
  endtask

  task automatic queue_message(input logic [LenW-1:0] size, input hdr_kind_e kind,
                               input logic defl);
    case (kind)
      HDR_SMALL: framed_stream.push_back({1'b0, size[6:0]});
      HDR_MEDIUM: begin
        framed_stream.push_back({1'b1, size[6:0]});
        framed_stream.push_back({1'b0, defl, size[12:7]});
      end
      default: begin
        framed_stream.push_back({1'b1, size[6:0]});
        framed_stream.push_back({1'b1, size[13:7]});
        framed_stream.push_back(size[21:14]);
      end
    endcase
    for (int i = 0; i < size; i++) framed_stream.push_back(ByteW'($urandom_range(0, 255)));
  endtask

  function automatic int pick_gap(logic burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxPrinted) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int idx, input logic [LenW-1:0] got,
                             input logic [LenW-1:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("result %0d %s: got %0h expected %0h", idx, name, got, exp));
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  int   gap_left = 0;
  logic in_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_step(in_byte);
        bytes_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (framed_stream.size() != 0) begin
          in_byte  <= framed_stream.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 99) == 0) in_burst = ~in_burst;
          gap_left <= pick_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int   stall_left = 0;
  logic out_burst  = 1'b0;

  always @(posedge clk) begin : monitor
    result_t exp_r;
    int      n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_expect.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", results_seen));
        end else begin
          exp_r = deframed_expect.pop_front();
          check_field("out_byte", results_seen, LenW'(out_byte), LenW'(exp_r.out_byte));
          check_field("first_of_message", results_seen, LenW'(first_of_message),
                      LenW'(exp_r.first_of_message));
          check_field("last_of_message", results_seen, LenW'(last_of_message),
                      LenW'(exp_r.last_of_message));
          check_field("empty_message", results_seen, LenW'(empty_message),
                      LenW'(exp_r.empty_message));
          check_field("huffman_coded", results_seen, LenW'(huffman_coded),
                      LenW'(exp_r.huffman_coded));
          check_field("deflated", results_seen, LenW'(deflated), LenW'(exp_r.deflated));
          check_field("message_length", results_seen, message_length, exp_r.message_length);
        end
        results_seen++;
        if ($urandom_range(0, 99) == 0) out_burst = ~out_burst;
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!out_burst && $urandom_range(0, 3) == 0) begin
        n = pick_gap(1'b0);
        out_stall  <= (n != 0);
        stall_left <= (n > 0) ? n - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int        size;
    int        r;
    hdr_kind_e kind;

    // empty small, one-byte and two-byte small, empty medium both codings,
    // medium deflated and huffman one-byte, empty large, one-byte large
    framed_stream = {8'h00, 8'h01, 8'hff, 8'h02, 8'h00, 8'ha5, 8'h80, 8'h00,
                     8'h80, 8'h40, 8'h81, 8'h40, 8'h5a, 8'h80, 8'h80, 8'h00,
                     8'h81, 8'h80, 8'h00, 8'h3c, 8'h81, 8'h00, 8'h7e};

    while (framed_stream.size() < RandomBytes) begin
      r = $urandom_range(0, 99);
      if (r < 8) size = 0;
      else if (r < 70) size = $urandom_range(1, 8);
      else if (r < 93) size = $urandom_range(9, 40);
      else if (r < 99) size = $urandom_range(41, 300);
      else size = $urandom_range(301, 700);
      if (size < 128) kind = hdr_kind_e'($urandom_range(0, 2));
      else kind = hdr_kind_e'($urandom_range(1, 2));
      queue_message(LenW'(size), kind, 1'($urandom_range(0, 1)));
    end

    // largest size the header can carry, only the head of its payload is sent
    framed_stream.push_back(8'hff);
    framed_stream.push_back(8'hff);
    framed_stream.push_back(8'hff);
    repeat (5) framed_stream.push_back(ByteW'($urandom_range(0, 255)));

    total_bytes = framed_stream.size();

    while (bytes_sent != total_bytes) @(posedge clk);
    while (deframed_expect.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d stream bytes: %0d headers, %0d empty messages, %0d payload bytes",
             total_bytes, msg_count, empty_count, payload_count);
    $display("checked %0d result requests under random idling on both sides", results_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
